// File: rtl/core/lsq_pkg.sv
`timescale 1ns / 1ps
package lsq_pkg;
    localparam int MaxPointsDefault = 1024;
    localparam int SumW = 34;
    localparam int ProdW = 58;
    localparam int WideW = 128;

    typedef struct packed {
        logic signed [23:0] x_value;
        logic signed [23:0] y_value;
        logic               last_point;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic               fit_status;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_DEN_MUL1,
        ST_DEN_MUL2,
        ST_DEN_CHK,
        ST_SN_MUL1,
        ST_SN_MUL2,
        ST_DIV_SN,
        ST_IN_MUL1,
        ST_IN_MUL2,
        ST_DIV_IN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_N_SXX,
        MUL_SX_SX,
        MUL_N_SXY,
        MUL_SX_SY,
        MUL_SY_SXX,
        MUL_SX_SXY
    } mul_sel_t;

    typedef struct packed {
        logic     acc_en;
        logic     clear;
        logic     mul_run;
        mul_sel_t mul_sel;
        logic     p1_latch;
        logic     den_latch;
        logic     div_start;
        logic     div_sn;
        logic     div_step;
        logic     slope_latch;
        logic     out_load;
        logic     out_degen;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_bad;
    } status_t;
endpackage

// File: rtl/core/lsq_ctrl.sv
`timescale 1ns / 1ps
module lsq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    input  lsq_pkg::status_t status,
    output lsq_pkg::cmd_t    cmd
);
    lsq_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsq_pkg::ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsq_pkg::ST_ACC:
                if (in_valid && in_last) state_next = lsq_pkg::ST_DEN_MUL1;
            lsq_pkg::ST_DEN_MUL1: if (status.mul_done) state_next = lsq_pkg::ST_DEN_MUL2;
            lsq_pkg::ST_DEN_MUL2: if (status.mul_done) state_next = lsq_pkg::ST_DEN_CHK;
            lsq_pkg::ST_DEN_CHK:
                state_next = status.den_bad ? lsq_pkg::ST_OUT : lsq_pkg::ST_SN_MUL1;
            lsq_pkg::ST_SN_MUL1: if (status.mul_done) state_next = lsq_pkg::ST_SN_MUL2;
            lsq_pkg::ST_SN_MUL2: if (status.mul_done) state_next = lsq_pkg::ST_DIV_SN;
            lsq_pkg::ST_DIV_SN: if (status.div_done) state_next = lsq_pkg::ST_IN_MUL1;
            lsq_pkg::ST_IN_MUL1: if (status.mul_done) state_next = lsq_pkg::ST_IN_MUL2;
            lsq_pkg::ST_IN_MUL2: if (status.mul_done) state_next = lsq_pkg::ST_DIV_IN;
            lsq_pkg::ST_DIV_IN: if (status.div_done) state_next = lsq_pkg::ST_OUT;
            lsq_pkg::ST_OUT:
                if (!out_valid_reg || out_ready) state_next = lsq_pkg::ST_ACC;
            default: state_next = lsq_pkg::ST_ACC;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            lsq_pkg::ST_ACC:
            begin
                in_ready = 1'b1;
                cmd.acc_en = in_valid;
            end
            lsq_pkg::ST_DEN_MUL1:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = lsq_pkg::MUL_N_SXX;
                cmd.p1_latch = status.mul_done;
            end
            lsq_pkg::ST_DEN_MUL2:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = lsq_pkg::MUL_SX_SX;
                cmd.den_latch = status.mul_done;
            end
            lsq_pkg::ST_DEN_CHK: ;
            lsq_pkg::ST_SN_MUL1:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = lsq_pkg::MUL_N_SXY;
                cmd.p1_latch = status.mul_done;
            end
            lsq_pkg::ST_SN_MUL2:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = lsq_pkg::MUL_SX_SY;
                cmd.div_start = status.mul_done;
                cmd.div_sn = 1'b1;
            end
            lsq_pkg::ST_DIV_SN:
            begin
                cmd.div_step = 1'b1;
                cmd.slope_latch = status.div_done;
            end
            lsq_pkg::ST_IN_MUL1:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = lsq_pkg::MUL_SY_SXX;
                cmd.p1_latch = status.mul_done;
            end
            lsq_pkg::ST_IN_MUL2:
            begin
                cmd.mul_run = 1'b1;
                cmd.mul_sel = lsq_pkg::MUL_SX_SXY;
                cmd.div_start = status.mul_done;
            end
            lsq_pkg::ST_DIV_IN:
                cmd.div_step = 1'b1;
            lsq_pkg::ST_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_degen = status.den_bad;
                    cmd.clear = 1'b1;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end
endmodule

// File: rtl/core/lsq_dp.sv
`timescale 1ns / 1ps
module lsq_dp
#(
    parameter int MAX_POINTS = lsq_pkg::MaxPointsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lsq_pkg::in_word_t  in_word,
    input  lsq_pkg::cmd_t      cmd,
    output lsq_pkg::status_t   status,
    output lsq_pkg::out_word_t out_word
);
    localparam int CntW = $clog2(MAX_POINTS + 1);
    localparam int SW = lsq_pkg::SumW;
    localparam int PW = lsq_pkg::ProdW;
    localparam int WW = lsq_pkg::WideW;

    logic [CntW-1:0] cnt_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [PW-1:0] sxy_reg, sxx_reg;
    logic signed [47:0] pxy, pxx;
    logic cnt_full;

    assign pxy = in_word.x_value * in_word.y_value;
    assign pxx = in_word.x_value * in_word.x_value;
    assign cnt_full = (cnt_reg >= CntW'(MAX_POINTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            cnt_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
        end
        else if (cmd.acc_en && !cnt_full)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            sx_reg <= sx_reg + SW'(in_word.x_value);
            sy_reg <= sy_reg + SW'(in_word.y_value);
            sxy_reg <= sxy_reg + PW'(pxy);
            sxx_reg <= sxx_reg + PW'(pxx);
        end
    end

    // Signed 64x64 product on one 32x32 multiplier, four partials, one per cycle.
    logic signed [63:0] opa, opb;
    logic [63:0] abs_a, abs_b;
    logic mneg;
    logic [1:0] mcnt_reg;
    logic [WW-1:0] macc_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] part;
    logic [WW-1:0] part_sh;
    logic [WW-1:0] mul_fin;
    logic [WW-1:0] prod_signed;
    logic [WW-1:0] p1_reg;
    logic [WW-1:0] diff;

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.mul_sel)
            lsq_pkg::MUL_N_SXX:
            begin
                opa = 64'({1'b0, cnt_reg});
                opb = 64'(sxx_reg);
            end
            lsq_pkg::MUL_SX_SX:
            begin
                opa = 64'(sx_reg);
                opb = 64'(sx_reg);
            end
            lsq_pkg::MUL_N_SXY:
            begin
                opa = 64'({1'b0, cnt_reg});
                opb = 64'(sxy_reg);
            end
            lsq_pkg::MUL_SX_SY:
            begin
                opa = 64'(sx_reg);
                opb = 64'(sy_reg);
            end
            lsq_pkg::MUL_SY_SXX:
            begin
                opa = 64'(sy_reg);
                opb = 64'(sxx_reg);
            end
            lsq_pkg::MUL_SX_SXY:
            begin
                opa = 64'(sx_reg);
                opb = 64'(sxy_reg);
            end
            default: ;
        endcase
        abs_a = opa[63] ? 64'(-opa) : 64'(opa);
        abs_b = opb[63] ? 64'(-opb) : 64'(opb);
        mneg = opa[63] ^ opb[63];
    end

    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:
            begin
                mul_a = abs_a[31:0];
                mul_b = abs_b[31:0];
                part_sh = WW'(part);
            end
            2'd1:
            begin
                mul_a = abs_a[31:0];
                mul_b = abs_b[63:32];
                part_sh = {32'd0, part, 32'd0};
            end
            2'd2:
            begin
                mul_a = abs_a[63:32];
                mul_b = abs_b[31:0];
                part_sh = {32'd0, part, 32'd0};
            end
            2'd3:
            begin
                mul_a = abs_a[63:32];
                mul_b = abs_b[63:32];
                part_sh = {part, 64'd0};
            end
        endcase
    end

    assign part = mul_a * mul_b;
    assign mul_fin = macc_reg + part_sh;
    assign prod_signed = mneg ? WW'(-mul_fin) : mul_fin;
    assign diff = p1_reg - prod_signed;
    assign status.mul_done = cmd.mul_run && (mcnt_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
            macc_reg <= '0;
        end
        else if (cmd.mul_run)
        begin
            mcnt_reg <= mcnt_reg + 2'd1;
            macc_reg <= (mcnt_reg == 2'd3) ? '0 : mul_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p1_latch)
            p1_reg <= prod_signed;
    end

    // Denominator
    logic [WW-1:0] den_reg;
    logic den_bad_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.den_latch)
        begin
            den_reg <= diff;
            den_bad_reg <= diff[WW-1] || (diff == '0);
        end
    end
    assign status.den_bad = den_bad_reg;

    // Restoring divider, one bit per cycle over 128 bits
    logic [WW-1:0] num_val;
    logic [WW-1:0] dq_reg;
    logic [WW-1:0] rem_reg;
    logic dneg_reg;
    logic [7:0] dcnt_reg;
    logic [WW-1:0] rem_sh;
    logic rem_ge;
    logic [WW:0] rem_ext;

    assign num_val = cmd.div_sn ? {diff[WW-17:0], 16'd0} : diff;
    assign rem_ext = {rem_reg, dq_reg[WW-1]};
    assign rem_ge = rem_ext >= {1'b0, den_reg};
    assign rem_sh = rem_ge ? WW'(rem_ext - {1'b0, den_reg}) : rem_ext[WW-1:0];
    assign status.div_done = (dcnt_reg == 8'd0);

    logic [31:0] sat_q;
    always_comb
    begin
        if (!dneg_reg)
            sat_q = (dq_reg > WW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dq_reg[31:0];
        else if (dq_reg > WW'(32'h80000000))
            sat_q = 32'h80000000;
        else
            sat_q = 32'(-dq_reg[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= 8'(WW);
        else if (cmd.div_step && dcnt_reg != 8'd0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dneg_reg <= num_val[WW-1];
            dq_reg <= num_val[WW-1] ? WW'(-num_val) : num_val;
            rem_reg <= '0;
        end
        else if (cmd.div_step && dcnt_reg != 8'd0)
        begin
            rem_reg <= rem_sh;
            dq_reg <= {dq_reg[WW-2:0], rem_ge};
        end
    end

    logic [31:0] slope_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.slope_latch)
            slope_reg <= sat_q;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_word.slope <= cmd.out_degen ? '0 : slope_reg;
            out_word.intercept <= cmd.out_degen ? '0 : sat_q;
            out_word.fit_status <= cmd.out_degen;
        end
    end
endmodule

// File: rtl/core/least_squares_line_fit_unit.sv
`timescale 1ns / 1ps
// Least-squares line fit.
// in_* channel: one word per (x, y) pair, Q8.16; last_point closes a data set.
// out_* channel: one word per data set: slope, intercept (Q16.16, saturated)
// and fit_status (1 when x has no spread; slope and intercept are then 0).
// Pairs are accumulated at one word per cycle; pairs past MAX_POINTS are dropped.
// After the last pair the block stops taking words while it forms the
// denominator and two numerators on a 32x32 multiplier (four partials per
// product, six products) and runs two 128-step restoring divisions; a
// degenerate set skips the numerators and divisions. out_valid rises in the
// same cycle that input resumes.
// The result sits in an output register; if the receiver stalls, the block
// holds it and waits before clearing the sums, then takes input again.
// Reset clears the count, the sums and the output valid flag.
module least_squares_line_fit_unit
#(
    parameter int MAX_POINTS = lsq_pkg::MaxPointsDefault
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsq_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lsq_pkg::out_word_t out_data
);
    lsq_pkg::cmd_t cmd;
    lsq_pkg::status_t status;

    lsq_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_last(in_data.last_point),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .cmd(cmd)
    );

    lsq_dp #(.MAX_POINTS(MAX_POINTS)) u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_word(in_data),
        .cmd(cmd),
        .status(status),
        .out_word(out_data)
    );
endmodule
